// ----- src/mbe_pkg.sv -----
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int ImageWidth  = 1024;
  localparam int ImageHeight = 1024;
  localparam int MaxIter     = 30;

  localparam int IterW    = $clog2(MaxIter + 1);
  localparam int FracBits = 28;
  localparam int WideW    = 66;

  // |z|^2 threshold of 4 in Q8.56
  localparam logic [63:0] EscapeSq = 64'(4) << (2 * FracBits);

  localparam longint unsigned ColorDen =
    64'(MaxIter) * 64'(MaxIter) * 64'(MaxIter) * 64'(MaxIter);

  typedef struct packed {
    logic signed [31:0] left_edge;
    logic signed [31:0] top_edge;
    logic signed [31:0] x_step;
    logic signed [31:0] y_step;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic map_mul;
    logic load_c;
    logic iter_mul;
    logic iter_upd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic finish;
    logic out_free;
  } status_t;

  typedef enum logic [1:0] {
    RegLeftEdge = 2'd0,
    RegTopEdge  = 2'd1,
    RegXStep    = 2'd2,
    RegYStep    = 2'd3
  } reg_idx_e;

  function automatic logic signed [31:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [31:0] r;
    if (v > WideW'(signed'(32'h7fff_ffff))) begin
      r = 32'sh7fff_ffff;
    end else if (v < WideW'(signed'(32'h8000_0000))) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor(num / den) by compare and subtract, quotient below 256
  function automatic logic [7:0] div_floor8(input longint unsigned num,
                                            input longint unsigned den);
    logic [7:0]      q;
    longint unsigned rem;
    rem = num;
    q   = '0;
    for (int i = 7; i >= 0; i--) begin
      if (rem >= (den << i)) begin
        rem  = rem - (den << i);
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // evaluated at elaboration: {red, green, blue} per iteration count
  function automatic logic [MaxIter:0][23:0] color_lut();
    logic [MaxIter:0][23:0] lut;
    longint unsigned k;
    longint unsigned d;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    for (int i = 0; i <= MaxIter; i++) begin
      k = 64'(i);
      d = 64'(MaxIter) - k;
      r = div_floor8(64'(9 * 255) * d * k * k * k, ColorDen);
      g = div_floor8(64'(15 * 255) * d * d * k * k, ColorDen);
      b = div_floor8(64'(17 * 255) * d * d * d * k, 2 * ColorDen);
      lut[i] = {r, g, b};
    end
    return lut;
  endfunction

  localparam logic [MaxIter:0][23:0] ColorLut = color_lut();

endpackage

// ----- src/mbe_cfg.sv -----
`timescale 1ns / 1ps

module mbe_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mbe_pkg::cfg_t      cfg_o
);
  import mbe_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_edge <= -32'sd469762048;
      cfg_q.top_edge  <= -32'sd67108864;
      cfg_q.x_step    <= 32'sd524288;
      cfg_q.y_step    <= 32'sd524288;
    end else if (wr_en) begin
      case (idx)
        RegLeftEdge: cfg_q.left_edge <= pwdata;
        RegTopEdge:  cfg_q.top_edge  <= pwdata;
        RegXStep:    cfg_q.x_step    <= pwdata;
        RegYStep:    cfg_q.y_step    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegLeftEdge: prdata = cfg_q.left_edge;
      RegTopEdge:  prdata = cfg_q.top_edge;
      RegXStep:    prdata = cfg_q.x_step;
      RegYStep:    prdata = cfg_q.y_step;
      default:     prdata = '0;
    endcase
  end

endmodule

// ----- src/mbe_ctrl.sv -----
`timescale 1ns / 1ps

module mbe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mbe_pkg::status_t status_i,
  output mbe_pkg::cmd_t    cmd_o
);
  import mbe_pkg::*;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMap  = 6'b000010,
    StCadd = 6'b000100,
    StMul  = 6'b001000,
    StUpd  = 6'b010000,
    StHold = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StMap;
        end
      end
      StMap: begin
        cmd_o.map_mul = 1'b1;
        state_d       = StCadd;
      end
      StCadd: begin
        cmd_o.load_c = 1'b1;
        state_d      = StMul;
      end
      StMul: begin
        cmd_o.iter_mul = 1'b1;
        state_d        = StUpd;
      end
      StUpd: begin
        if (status_i.finish) begin
          state_d = StHold;
        end else begin
          cmd_o.iter_upd = 1'b1;
          state_d        = StMul;
        end
      end
      StHold: begin
        // wait for the output register to free up
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ----- src/mbe_dp.sv -----
`timescale 1ns / 1ps

module mbe_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mbe_pkg::cmd_t    cmd_i,
  output mbe_pkg::status_t status_o,
  input  mbe_pkg::cfg_t    cfg_i,
  input  logic [9:0]       pixel_x_i,
  input  logic [9:0]       pixel_y_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [4:0]       iterations_o
);
  import mbe_pkg::*;

  logic [9:0]              px_q, py_q;
  logic [9:0]              px_clamp, py_clamp;
  logic signed [31:0]      cre_q, cim_q, zre_q, zim_q;
  logic [IterW-1:0]        n_q;
  logic signed [63:0]      prod0_q, prod1_q, prod2_q;
  logic signed [31:0]      ma0, mb0, ma1, mb1;
  logic signed [WideW-1:0] map_re, map_im, sq_diff, re_new, im_new;
  logic [63:0]             sq_sum;
  logic                    escape;
  logic                    out_valid_q;
  logic [7:0]              red_q, green_q, blue_q;
  logic [4:0]              iter_q;

  // coordinates past the image edge snap to the last column or row
  always_comb begin
    px_clamp = pixel_x_i;
    py_clamp = pixel_y_i;
    if (17'(pixel_x_i) >= 17'(ImageWidth)) begin
      px_clamp = 10'(ImageWidth - 1);
    end
    if (17'(pixel_y_i) >= 17'(ImageHeight)) begin
      py_clamp = 10'(ImageHeight - 1);
    end
  end

  // the two square multipliers also do the pixel-to-plane mapping
  always_comb begin
    if (cmd_i.map_mul) begin
      ma0 = signed'(32'(px_q));
      mb0 = cfg_i.x_step;
      ma1 = signed'(32'(py_q));
      mb1 = cfg_i.y_step;
    end else begin
      ma0 = zre_q;
      mb0 = zre_q;
      ma1 = zim_q;
      mb1 = zim_q;
    end
  end

  assign map_re  = WideW'(cfg_i.left_edge) + WideW'(prod0_q);
  assign map_im  = WideW'(cfg_i.top_edge) + WideW'(prod1_q);
  assign sq_diff = WideW'(prod0_q) - WideW'(prod1_q);
  assign re_new  = (sq_diff >>> FracBits) + WideW'(cre_q);
  assign im_new  = (WideW'(prod2_q) >>> (FracBits - 1)) + WideW'(cim_q);

  // both squares are non-negative, their sum is at most 2^63
  assign sq_sum = unsigned'(prod0_q) + unsigned'(prod1_q);
  assign escape = (sq_sum >= EscapeSq);

  assign status_o.finish   = (n_q == IterW'(MaxIter)) || escape;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      px_q <= px_clamp;
      py_q <= py_clamp;
    end
    if (cmd_i.map_mul || cmd_i.iter_mul) begin
      prod0_q <= 64'(ma0) * 64'(mb0);
      prod1_q <= 64'(ma1) * 64'(mb1);
      prod2_q <= 64'(zre_q) * 64'(zim_q);
    end
    if (cmd_i.load_c) begin
      cre_q <= sat32(map_re);
      cim_q <= sat32(map_im);
      zre_q <= '0;
      zim_q <= '0;
      n_q   <= '0;
    end
    if (cmd_i.iter_upd) begin
      zre_q <= sat32(re_new);
      zim_q <= sat32(im_new);
      n_q   <= n_q + IterW'(1);
    end
    if (cmd_i.load_out) begin
      red_q   <= ColorLut[n_q][23:16];
      green_q <= ColorLut[n_q][15:8];
      blue_q  <= ColorLut[n_q][7:0];
      iter_q  <= 5'(n_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign iterations_o = iter_q;

endmodule

// ----- src/mandelbrot_escape_time_pixel.sv -----
`timescale 1ns / 1ps

// Escape-time pixel engine. One pixel coordinate (pixel_x_i, pixel_y_i) is
// taken on the input valid/ready channel; it is mapped to a point c of the
// complex plane from the left_edge, top_edge, x_step and y_step registers
// (signed Q4.28, APB-style port at byte addresses 0, 4, 8, 12) and
// z = z*z + c is iterated until |z|^2 >= 4 or the iteration limit.
// The output channel delivers one word per pixel: the iteration count and
// its colour from a constant lookup table (black inside the set).
// The iteration loop alternates a step in the three 32x32 multipliers,
// two of them shared with the pixel-to-plane mapping, and a step in the
// escape test and z update.
// One pixel is in flight at a time; in_ready_o is high while the engine is
// idle, also while a finished word waits in the output register.
// If the receiver stalls, the next pixel is computed and then held until
// the output register frees up.
// Reset clears the controller and output valid and loads the registers with
// their defaults: left edge -1.75, top edge -0.25, steps 2^-9.

module mandelbrot_escape_time_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [9:0]  pixel_x_i,
  input  logic [9:0]  pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [4:0]  iterations_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mbe_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  mbe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mbe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_i        (cfg),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .iterations_o (iterations_o)
  );

endmodule

// ----- src/mbe_chk.sv -----
`timescale 1ns / 1ps

module mbe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o,
  input logic [4:0]  iterations_o
);
  import mbe_pkg::*;

  // a stalled word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // one pixel in flight at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second pixel accepted while busy");

  // no word can appear right after a pixel is taken
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("output appeared too early");

  // pixels inside the set are black
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (iterations_o == 5'(MaxIter))
      |-> (red_o == 8'd0) && (green_o == 8'd0) && (blue_o == 8'd0))
    else $error("limit reached but colour not black");

endmodule

bind mandelbrot_escape_time_pixel mbe_chk u_mbe_chk (.*);
